>>> rtl/core/joystick_channel_calibrator_assert.svh
// Assertion macros used by the joystick channel calibrator top level.
`ifndef JOYSTICK_CHANNEL_CALIBRATOR_ASSERT_SVH
`define JOYSTICK_CHANNEL_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JCC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JCC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/jcc_pkg.sv
// Package with types, constants and codes of the joystick channel calibrator.
`default_nettype none

package jcc_pkg;

  localparam int ADC_W    = 12;
  localparam int CMD_W    = 11;
  localparam int OFFSET_W = 16;
  localparam int COUNT_W  = 8;

  localparam int CMD_MIN     = 1000;
  localparam int CMD_MAX     = 2000;
  localparam int CMD_MID     = 1500;
  localparam int UNLOCK_LVL  = 1800;

  localparam int CAL_SAMPLES_DEFAULT = 50;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [1:0]          req_t;
  typedef logic [ADC_W-1:0]    adc_t;
  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam req_t REQ_SCAN  = 2'd0;
  localparam req_t REQ_LEFT  = 2'd1;
  localparam req_t REQ_RIGHT = 2'd2;

  localparam logic [0:0] REG_APPLY_OFFSETS = 1'b0;

  typedef struct packed {
    logic clear;
    logic accum;
    logic finish;
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/jcc_scan_if.sv
// Channel interface carrying one scan of joystick samples.
`default_nettype none

interface jcc_scan_if;
  import jcc_pkg::*;

  logic valid;
  logic ready;
  req_t req_type;
  adc_t adc_roll;
  adc_t adc_pitch;
  adc_t adc_throttle;
  adc_t adc_yaw;

  modport source (output valid, req_type, adc_roll, adc_pitch, adc_throttle, adc_yaw,
                  input ready);
  modport sink (input valid, req_type, adc_roll, adc_pitch, adc_throttle, adc_yaw,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/jcc_result_if.sv
// Channel interface carrying one set of calibrated control values.
`default_nettype none

interface jcc_result_if;
  import jcc_pkg::*;

  logic valid;
  logic ready;
  cmd_t pitch_cmd;
  cmd_t roll_cmd;
  cmd_t throttle_cmd;
  cmd_t yaw_cmd;
  logic calib_done;
  logic unlock_request;

  modport source (output valid, pitch_cmd, roll_cmd, throttle_cmd, yaw_cmd, calib_done,
                  unlock_request, input ready);
  modport sink (input valid, pitch_cmd, roll_cmd, throttle_cmd, yaw_cmd, calib_done,
                unlock_request, output ready);
endinterface

`default_nettype wire

>>> rtl/core/jcc_lane.sv
// One channel lane: scaling, offset, clamp and calibration offset update.
`default_nettype none

module jcc_lane #(
  parameter int CAL_SAMPLES = jcc_pkg::CAL_SAMPLES_DEFAULT,
  parameter bit INVERT      = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                apply,
  input  jcc_pkg::adc_t       sample,
  input  jcc_pkg::lane_ctrl_t ctrl,
  output jcc_pkg::cmd_t       value
);
  import jcc_pkg::*;

  localparam int DivShift = OFFSET_W + $clog2(CAL_SAMPLES);
  localparam int DivMulW  = OFFSET_W + 2;
  localparam int ProdW    = OFFSET_W + DivMulW;
  localparam logic [DivMulW-1:0] DivMul =
    DivMulW'(((64'd1 << DivShift) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic signed [OFFSET_W+1:0] TotMin = (OFFSET_W+2)'(CMD_MIN);
  localparam logic signed [OFFSET_W+1:0] TotMax = (OFFSET_W+2)'(CMD_MAX);

  logic [ADC_W-3:0]            scaled;
  logic [ADC_W-1:0]            base;
  logic signed [OFFSET_W+1:0]  total;
  offset_t                     offset;
  offset_t                     offset_next;
  offset_t                     acc;
  offset_t                     mag;
  offset_t                     quot;
  offset_t                     divided;
  logic [ProdW-1:0]            prod;

  always_comb begin
    scaled = sample[ADC_W-1:2];
    if (INVERT) begin
      base = ADC_W'(CMD_MAX) - {2'b00, scaled};
    end else begin
      base = ADC_W'(CMD_MIN) + {2'b00, scaled};
    end
    total = $signed({{(OFFSET_W+2-ADC_W){1'b0}}, base});
    if (apply) begin
      total = total + $signed({{2{offset[OFFSET_W-1]}}, offset});
    end
    if (total < TotMin) begin
      value = CMD_W'(CMD_MIN);
    end else if (total > TotMax) begin
      value = CMD_W'(CMD_MAX);
    end else begin
      value = total[CMD_W-1:0];
    end
  end

  always_comb begin
    acc     = offset + (OFFSET_W'(CMD_MID) - {{(OFFSET_W-CMD_W){1'b0}}, value});
    mag     = acc[OFFSET_W-1] ? (OFFSET_W'(0) - acc) : acc;
    prod    = ProdW'(mag) * ProdW'(DivMul);
    quot    = OFFSET_W'(prod >> DivShift);
    divided = acc[OFFSET_W-1] ? (OFFSET_W'(0) - quot) : quot;
    offset_next = offset;
    if (en && ctrl.clear) begin
      offset_next = '0;
    end else if (en && ctrl.accum) begin
      offset_next = ctrl.finish ? divided : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else begin
      offset <= offset_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/jcc_merge.sv
// Merge stage: calibration counters, per-pair lane control, done and unlock flags.
`default_nettype none

module jcc_merge #(
  parameter int CAL_SAMPLES = jcc_pkg::CAL_SAMPLES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  jcc_pkg::req_t       req,
  input  jcc_pkg::cmd_t       pitch,
  input  jcc_pkg::cmd_t       throttle,
  output jcc_pkg::lane_ctrl_t left_ctrl,
  output jcc_pkg::lane_ctrl_t right_ctrl,
  output logic                done,
  output logic                unlock
);
  import jcc_pkg::*;

  localparam count_t CalTarget = COUNT_W'(CAL_SAMPLES);

  count_t left_count;
  count_t left_count_next;
  count_t right_count;
  count_t right_count_next;
  count_t left_inc;
  count_t right_inc;
  logic   left_hit;
  logic   right_hit;

  always_comb begin
    left_hit  = (req == REQ_LEFT);
    right_hit = (req == REQ_RIGHT);
    left_inc  = left_count + COUNT_W'(1);
    right_inc = right_count + COUNT_W'(1);

    left_ctrl.clear   = left_hit && (left_count == '0);
    left_ctrl.accum   = left_hit && (left_count != '0);
    left_ctrl.finish  = (left_inc == CalTarget);
    right_ctrl.clear  = right_hit && (right_count == '0);
    right_ctrl.accum  = right_hit && (right_count != '0);
    right_ctrl.finish = (right_inc == CalTarget);

    done   = (left_hit && left_ctrl.finish) || (right_hit && right_ctrl.finish);
    unlock = (pitch > CMD_W'(UNLOCK_LVL)) && (throttle > CMD_W'(UNLOCK_LVL));

    left_count_next  = (en && left_hit) ? left_inc : left_count;
    right_count_next = (en && right_hit) ? right_inc : right_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
    end else begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/joystick_channel_calibrator.sv
// Top level of the joystick channel calibrator: four channel lanes, merge stage and APB port.
`default_nettype none
`include "joystick_channel_calibrator_assert.svh"

// The calibrator takes one scan per clock cycle while its output register is not stalled,
// and presents its result in that register in the cycle after the scan transaction, so
// a new scan is accepted in the same cycle as the previous result is taken. Each of the
// four channel lanes scales, offsets and clamps its sample and updates its stored calibration
// offset as the scan is accepted; the offset update, with its divide-by-constant multiplier,
// is the path that sets the cycle time. The apply_offsets register is at byte address 0 of
// the APB port. The user must write it only while no scan is in flight; nothing enforces it.
module joystick_channel_calibrator #(
  parameter int CAL_SAMPLES = jcc_pkg::CAL_SAMPLES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  jcc_scan_if.sink                       scan,
  jcc_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jcc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jcc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import jcc_pkg::*;

  logic       apply_offsets;
  logic       apply_offsets_next;
  logic       scan_accept;
  logic       reg_sel;
  cmd_t       pitch_val;
  cmd_t       roll_val;
  cmd_t       throttle_val;
  cmd_t       yaw_val;
  lane_ctrl_t left_ctrl;
  lane_ctrl_t right_ctrl;
  logic       done_val;
  logic       unlock_val;
  logic       out_valid;
  logic       out_valid_next;
  logic       out_stall;
  logic       pitch_ok;
  logic       unlock_seen;
  logic       unlock_ok;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_APPLY_OFFSETS);
  assign prdata  = reg_sel ? {{(CFG_DATA_W-1){1'b0}}, apply_offsets} : '0;

  always_comb begin
    apply_offsets_next = apply_offsets;
    if (psel && penable && pwrite && pready && reg_sel) begin
      apply_offsets_next = pwdata[0];
    end
  end

  assign scan.ready   = !out_valid || result.ready;
  assign scan_accept  = scan.valid && scan.ready;
  assign result.valid = out_valid;

  jcc_lane #(.CAL_SAMPLES(CAL_SAMPLES), .INVERT(1'b0)) u_lane_pitch (
    .clk(clk), .rst(rst), .en(scan_accept), .apply(apply_offsets),
    .sample(scan.adc_pitch), .ctrl(right_ctrl), .value(pitch_val)
  );

  jcc_lane #(.CAL_SAMPLES(CAL_SAMPLES), .INVERT(1'b0)) u_lane_roll (
    .clk(clk), .rst(rst), .en(scan_accept), .apply(apply_offsets),
    .sample(scan.adc_roll), .ctrl(right_ctrl), .value(roll_val)
  );

  jcc_lane #(.CAL_SAMPLES(CAL_SAMPLES), .INVERT(1'b1)) u_lane_throttle (
    .clk(clk), .rst(rst), .en(scan_accept), .apply(apply_offsets),
    .sample(scan.adc_throttle), .ctrl(left_ctrl), .value(throttle_val)
  );

  jcc_lane #(.CAL_SAMPLES(CAL_SAMPLES), .INVERT(1'b1)) u_lane_yaw (
    .clk(clk), .rst(rst), .en(scan_accept), .apply(apply_offsets),
    .sample(scan.adc_yaw), .ctrl(left_ctrl), .value(yaw_val)
  );

  jcc_merge #(.CAL_SAMPLES(CAL_SAMPLES)) u_merge (
    .clk(clk), .rst(rst), .en(scan_accept), .req(scan.req_type),
    .pitch(pitch_val), .throttle(throttle_val),
    .left_ctrl(left_ctrl), .right_ctrl(right_ctrl),
    .done(done_val), .unlock(unlock_val)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (scan_accept) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      apply_offsets <= 1'b0;
    end else begin
      out_valid     <= out_valid_next;
      apply_offsets <= apply_offsets_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_accept) begin
      result.pitch_cmd      <= pitch_val;
      result.roll_cmd       <= roll_val;
      result.throttle_cmd   <= throttle_val;
      result.yaw_cmd        <= yaw_val;
      result.calib_done     <= done_val;
      result.unlock_request <= unlock_val;
    end
  end

  assign out_stall   = out_valid && !result.ready;
  assign pitch_ok    = (result.pitch_cmd >= CMD_W'(CMD_MIN)) &&
                       (result.pitch_cmd <= CMD_W'(CMD_MAX));
  assign unlock_seen = out_valid && result.unlock_request;
  assign unlock_ok   = (result.pitch_cmd > CMD_W'(UNLOCK_LVL)) &&
                       (result.throttle_cmd > CMD_W'(UNLOCK_LVL));

  `JCC_ASSERT_NXT(a_accept_loads, clk, rst, scan_accept, out_valid, "No result after a scan.")
  `JCC_ASSERT_IMP(a_stall_blocks, clk, rst, out_stall, !scan_accept, "Scan taken while stalled.")
  `JCC_ASSERT_IMP(a_pitch_range, clk, rst, out_valid, pitch_ok, "Pitch command out of range.")
  `JCC_ASSERT_IMP(a_unlock_level, clk, rst, unlock_seen, unlock_ok, "Unlock flagged too low.")

endmodule

`default_nettype wire
